// ===== rtl/bmdi_pkg.sv =====
// Package for the body motor drag integrator.
// Holds item, configuration and status types, the fixed-point constants and the sequencer states.
// No dependencies.
package bmdi_pkg;

    // Number formats.
    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 16;
    localparam int ANGLE_FRAC = ANGLE_BITS - 4;

    // One turn in angle format, round(2*pi * 2^ANGLE_FRAC).
    localparam longint TWO_PI_Q32 = 64'd26986075409;
    localparam int TURN = int'((TWO_PI_Q32 + (64'd1 << (31 - ANGLE_FRAC))) >> (32 - ANGLE_FRAC));
    localparam int HALF_TURN = TURN / 2;

    // Reciprocal for the angle to phase scaling, floor(2^32 / TURN).
    localparam logic [17:0] PHASE_RECIP = 18'((64'd1 << 32) / TURN);

    // Sine polynomial coefficients, Q16.
    localparam int SIN_A = 102944;
    localparam int SIN_B = 2 * SIN_A - 163840;
    localparam int SIN_C = SIN_A - 98304;

    // Queue depth between front and back.
    localparam int QDEPTH = 2;

    // Payload widths on the stream ports.
    localparam int S_TDATA_W = 304;
    localparam int M_TDATA_W = 160;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_MOTOR  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } bmdi_action_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DRAG   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [15:0] drag_factor;
        logic [30:0] map_width;
        logic [30:0] map_height;
    } bmdi_cfg_t;

    // Below the action, the fields sit in the same bit order as on s_tdata,
    // with pos_x in the lowest bits.
    typedef struct packed {
        bmdi_action_t        action;
        logic signed [31:0]  motor_power;
        logic signed [31:0]  motor_angular_force;
        logic signed [31:0]  motor_radial_force;
        logic signed [15:0]  motor_offset;
        logic [30:0]         body_radius;
        logic signed [15:0]  vel_ang;
        logic signed [31:0]  vel_y;
        logic signed [31:0]  vel_x;
        logic signed [15:0]  heading;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_x;
    } bmdi_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_F0, ST_F1, ST_F2, ST_F3
    } bmdi_state_t;

    typedef struct packed {
        logic [1:0] count;
    } bmdi_front_status_t;

    typedef struct packed {
        bmdi_state_t state;
    } bmdi_back_status_t;

endpackage

// ===== rtl/bmdi_front.sv =====
// Front end of the body motor drag integrator: accepts transactions, drops unused actions
// and queues the rest for the back end. Depends on bmdi_pkg.
module bmdi_front
    import bmdi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  pop,
    output logic                  q_valid,
    output bmdi_item_t            q_item,
    output bmdi_front_status_t    status
);

    bmdi_item_t q_mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    bmdi_item_t in_item;
    logic       push;

    // Unpack the incoming transaction.
    always_comb begin
        in_item.action              = bmdi_action_t'(s_tuser);
        in_item.pos_x               = s_tdata[31:0];
        in_item.pos_y               = s_tdata[63:32];
        in_item.heading             = s_tdata[79:64];
        in_item.vel_x               = s_tdata[111:80];
        in_item.vel_y               = s_tdata[143:112];
        in_item.vel_ang             = s_tdata[159:144];
        in_item.body_radius         = s_tdata[190:160];
        in_item.motor_offset        = s_tdata[206:191];
        in_item.motor_radial_force  = s_tdata[238:207];
        in_item.motor_angular_force = s_tdata[270:239];
        in_item.motor_power         = s_tdata[302:271];
    end

    // Unused actions are accepted and dropped here.
    assign s_tready = (count_reg != 2'(QDEPTH));
    assign push     = s_tvalid && s_tready && (in_item.action != ACT_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign status.count = count_reg;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/bmdi_back.sv =====
// Back end of the body motor drag integrator: holds the body state and runs the motor
// and finish sequences, then drives the result register. Depends on bmdi_pkg.
module bmdi_back
    import bmdi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bmdi_cfg_t             cfg,
    input  logic                  q_valid,
    input  bmdi_item_t            q_item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output bmdi_back_status_t     status
);

    bmdi_state_t state_reg, state_next;
    logic        commit;

    // Body state.
    logic signed [31:0] body_x_reg, body_y_reg, vx_reg, vy_reg;
    logic signed [15:0] heading_reg, va_reg;
    logic [30:0]        r_reg;

    // Work registers.
    bmdi_item_t         wk_reg;
    logic [14:0]        ang_reg;
    logic [15:0]        q0_reg, phase_reg;
    logic signed [63:0] prod_f_reg, prod_g_reg;
    logic signed [31:0] f_reg, g_reg;
    logic [14:0]        z_reg [2];
    logic [14:0]        z2_reg [2];
    logic               neg_reg [2];
    logic [16:0]        t1_reg [2];
    logic [16:0]        t2_reg [2];
    logic signed [17:0] sin_reg [2];
    logic [63:0]        sqx_reg, sqy_reg;
    logic [31:0]        sqa_reg;
    logic [19:0]        k10_reg;
    logic [46:0]        hix_reg, hiy_reg;
    logic [31:0]        lox_reg, loy_reg;
    logic [22:0]        hia_reg;
    logic [35:0]        loa_reg;

    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // Combinational datapath values.
    logic signed [16:0] ang_sum;
    logic [32:0]        recip_prod;
    logic [30:0]        phase_rem;
    logic [15:0]        phase_fix;
    logic [15:0]        ph_c [2];
    logic [14:0]        z_c [2];
    logic [29:0]        zz_c [2];
    logic [27:0]        cz_c [2];
    logic [31:0]        tz_c [2];
    logic [31:0]        sz_c [2];
    logic [16:0]        mag_c [2];
    logic signed [49:0] fs_c [2];
    logic signed [31:0] vmot_c [2];
    logic signed [15:0] va_mot;
    logic signed [63:0] sq_vx, sq_vy;
    logic signed [31:0] sq_va;
    logic [63:0]        qx, qy;
    logic [31:0]        qa;
    logic [47:0]        dx, dy;
    logic [23:0]        da;
    logic signed [48:0] vx_drag, vy_drag, va_drag;
    logic signed [32:0] px, py, rr, hx, hy;
    logic signed [31:0] new_x, new_y;
    logic signed [16:0] hsum;
    logic [14:0]        hmod;
    logic signed [15:0] new_h;

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Reduce a two-word angle sum into [0, TURN) with parallel compares.
    function automatic logic [14:0] reduce_turn(logic signed [16:0] a);
        logic [17:0] v;
        v = 18'({a[16], a}) + 18'(3 * TURN);
        if (v >= 18'(5 * TURN)) begin
            return 15'(v - 18'(5 * TURN));
        end else if (v >= 18'(4 * TURN)) begin
            return 15'(v - 18'(4 * TURN));
        end else if (v >= 18'(3 * TURN)) begin
            return 15'(v - 18'(3 * TURN));
        end else if (v >= 18'(2 * TURN)) begin
            return 15'(v - 18'(2 * TURN));
        end else if (v >= 18'(TURN)) begin
            return 15'(v - 18'(TURN));
        end
        return 15'(v);
    endfunction

    // Quadratic drag toward zero without overshoot.
    function automatic logic signed [48:0] drag_apply(logic signed [48:0] v,
                                                      logic signed [48:0] d);
        logic signed [48:0] s;
        if (v < 0) begin
            s = v + d;
            return (s < 0) ? s : 49'sd0;
        end
        s = v - d;
        return (s > 0) ? s : 49'sd0;
    endfunction

    // Motor datapath.
    always_comb begin
        ang_sum    = 17'(heading_reg) + 17'(wk_reg.motor_offset);
        recip_prod = 33'(ang_reg) * 33'(PHASE_RECIP);
        phase_rem  = {ang_reg, 16'd0} - 31'(q0_reg) * 31'(TURN);
        phase_fix  = (phase_rem >= 31'(TURN)) ? q0_reg + 16'd1 : q0_reg;
        ph_c[0]    = phase_reg;
        ph_c[1]    = phase_reg + 16'd16384;
        for (int l = 0; l < 2; l++) begin
            z_c[l]   = ph_c[l][14] ? 15'(15'd16384 - {1'b0, ph_c[l][13:0]})
                                   : {1'b0, ph_c[l][13:0]};
            zz_c[l]  = 30'(z_c[l]) * 30'(z_c[l]);
            cz_c[l]  = 28'(SIN_C) * 28'(z2_reg[l]);
            tz_c[l]  = 32'(t1_reg[l]) * 32'(z2_reg[l]);
            sz_c[l]  = 32'(t2_reg[l]) * 32'(z_reg[l]);
            mag_c[l] = 17'(sz_c[l] >> 14);
            fs_c[l]  = 50'(f_reg) * 50'(sin_reg[l]);
        end
        vmot_c[0] = sat32(64'(vx_reg) + 64'(fs_c[0] >>> 16));
        vmot_c[1] = sat32(64'(vy_reg) + 64'(fs_c[1] >>> 16));
        va_mot    = sat16(64'(va_reg) + 64'(g_reg >>> (FRAC_BITS - ANGLE_FRAC)));
    end

    // Finish datapath.
    always_comb begin
        sq_vx   = 64'(vx_reg) * 64'(vx_reg);
        sq_vy   = 64'(vy_reg) * 64'(vy_reg);
        sq_va   = 32'(va_reg) * 32'(va_reg);
        qx      = sqx_reg >> FRAC_BITS;
        qy      = sqy_reg >> FRAC_BITS;
        qa      = sqa_reg >> ANGLE_FRAC;
        dx      = 48'(hix_reg) + 48'(lox_reg[31:16]);
        dy      = 48'(hiy_reg) + 48'(loy_reg[31:16]);
        da      = 24'(hia_reg) + 24'(loa_reg[35:16]);
        vx_drag = drag_apply(49'(vx_reg), signed'({1'b0, dx}));
        vy_drag = drag_apply(49'(vy_reg), signed'({1'b0, dy}));
        va_drag = drag_apply(49'(va_reg), signed'(49'(da)));
        px      = 33'(body_x_reg) + 33'(vx_reg);
        py      = 33'(body_y_reg) + 33'(vy_reg);
        rr      = signed'({2'b00, r_reg});
        hx      = signed'({2'b00, cfg.map_width}) - rr;
        hy      = signed'({2'b00, cfg.map_height}) - rr;
        new_x   = (px < rr) ? 32'(rr) : ((px > hx) ? 32'(hx) : 32'(px));
        new_y   = (py < rr) ? 32'(rr) : ((py > hy) ? 32'(hy) : 32'(py));
        hsum    = 17'(heading_reg) + 17'(va_reg);
        hmod    = reduce_turn(hsum);
        new_h   = (hmod >= 15'(HALF_TURN)) ? 16'(signed'({2'b00, hmod}) - 17'(TURN))
                                           : 16'(hmod);
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and control.
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop = 1'b1;
                    unique case (q_item.action)
                        ACT_MOTOR:  state_next = ST_M0;
                        ACT_FINISH: state_next = ST_F0;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_M0: state_next = ST_M1;
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_M5;
            ST_M5: state_next = ST_M6;
            ST_M6: state_next = ST_M7;
            ST_M7: state_next = ST_IDLE;
            ST_F0: state_next = ST_F1;
            ST_F1: state_next = ST_F2;
            ST_F2: state_next = ST_F3;
            ST_F3: begin
                if (!out_valid_reg || m_tready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Body state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_x_reg  <= '0;
            body_y_reg  <= '0;
            heading_reg <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
            va_reg      <= '0;
            r_reg       <= '0;
        end else begin
            if (pop && (q_item.action == ACT_LOAD)) begin
                body_x_reg  <= q_item.pos_x;
                body_y_reg  <= q_item.pos_y;
                heading_reg <= q_item.heading;
                vx_reg      <= q_item.vel_x;
                vy_reg      <= q_item.vel_y;
                va_reg      <= q_item.vel_ang;
                r_reg       <= q_item.body_radius;
            end
            if (state_reg == ST_M7) begin
                vx_reg <= vmot_c[0];
                vy_reg <= vmot_c[1];
                va_reg <= va_mot;
            end
            if (state_reg == ST_F2) begin
                vx_reg <= 32'(vx_drag);
                vy_reg <= 32'(vy_drag);
                va_reg <= 16'(va_drag);
            end
            if (commit) begin
                body_x_reg  <= new_x;
                body_y_reg  <= new_y;
                heading_reg <= new_h;
            end
        end
    end

    // Work registers along the motor and finish sequences.
    always_ff @(posedge aclk) begin
        if (pop) begin
            wk_reg <= q_item;
        end
        unique case (state_reg)
            ST_M0: begin
                ang_reg    <= reduce_turn(ang_sum);
                prod_f_reg <= 64'(wk_reg.motor_radial_force) * 64'(wk_reg.motor_power);
            end
            ST_M1: begin
                q0_reg     <= 16'(recip_prod >> 16);
                prod_g_reg <= 64'(wk_reg.motor_angular_force) * 64'(wk_reg.motor_power);
            end
            ST_M2: begin
                phase_reg <= phase_fix;
                f_reg     <= sat32(prod_f_reg >>> FRAC_BITS);
                g_reg     <= sat32(prod_g_reg >>> FRAC_BITS);
            end
            ST_M3: begin
                for (int l = 0; l < 2; l++) begin
                    z_reg[l]   <= z_c[l];
                    z2_reg[l]  <= 15'(zz_c[l] >> 14);
                    neg_reg[l] <= ph_c[l][15];
                end
            end
            ST_M4: begin
                for (int l = 0; l < 2; l++) begin
                    t1_reg[l] <= 17'(SIN_B - int'(cz_c[l] >> 14));
                end
            end
            ST_M5: begin
                for (int l = 0; l < 2; l++) begin
                    t2_reg[l] <= 17'(SIN_A - int'(tz_c[l] >> 14));
                end
            end
            ST_M6: begin
                for (int l = 0; l < 2; l++) begin
                    sin_reg[l] <= neg_reg[l] ? -signed'({1'b0, mag_c[l]})
                                             : signed'({1'b0, mag_c[l]});
                end
            end
            ST_F0: begin
                sqx_reg <= 64'(sq_vx);
                sqy_reg <= 64'(sq_vy);
                sqa_reg <= 32'(sq_va);
                k10_reg <= 20'(cfg.drag_factor) * 20'd10;
            end
            ST_F1: begin
                hix_reg <= 47'(qx[47:16]) * 47'(cfg.drag_factor);
                lox_reg <= 32'(qx[15:0]) * 32'(cfg.drag_factor);
                hiy_reg <= 47'(qy[47:16]) * 47'(cfg.drag_factor);
                loy_reg <= 32'(qy[15:0]) * 32'(cfg.drag_factor);
                hia_reg <= 23'(qa[18:16]) * 23'(k10_reg);
                loa_reg <= 36'(qa[15:0]) * 36'(k10_reg);
            end
            default: begin
            end
        endcase
    end

    // Result register: frees as soon as the receiver takes the transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_data_reg <= {va_reg, vy_reg, vx_reg, new_h, new_y, new_x};
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign status.state = state_reg;

endmodule

// ===== rtl/body_motor_drag_integrator.sv =====
// Top level of the body motor drag integrator: configuration registers, front queue and
// back sequencer. Depends on bmdi_pkg, bmdi_front and bmdi_back.
//
// Usage: transactions enter on the s_ channel; s_tuser selects load (0), motor (1) or
// finish (2); action 3 is accepted and ignored. A load latches the body state, each motor
// transaction adds its thrust to the velocities, and a finish applies drag, integrates
// position and heading, clamps to the map and sends one transaction on the m_ channel.
// A load is taken in the idle state, a motor runs through states M0 to M7 and a finish
// through F0 to F3 of the back sequencer; the motor sequence follows the chain of sine
// polynomial multiplies, each followed by a register. A result appears on m_tvalid the
// cycle after its finish completes. A two-entry queue lets the front keep accepting while
// the back works. When the receiver stalls, the result register holds and the next finish
// waits in its last step; the queue fills and then s_tready drops. Reset (aresetn low,
// synchronous) clears the body state to zero, empties the queue and the result register,
// and loads the default drag and map size. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while the block is idle; not enforced.
module body_motor_drag_integrator
    import bmdi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, heading, vel_x, vel_y, vel_ang, body_radius, motor_offset,
    // motor_radial_force, motor_angular_force, motor_power, one zero pad bit
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_pos_x, new_pos_y, new_heading, new_vel_x, new_vel_y, new_vel_ang
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_wdata
);

    bmdi_cfg_t          cfg_reg;
    logic               q_valid;
    bmdi_item_t         q_item;
    logic               pop;
    bmdi_front_status_t front_status;
    bmdi_back_status_t  back_status;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drag_factor <= 16'd6554;
            cfg_reg.map_width   <= 31'd52428800;
            cfg_reg.map_height  <= 31'd39321600;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DRAG:   cfg_reg.drag_factor <= cfg_wdata[15:0];
                CFG_WIDTH:  cfg_reg.map_width   <= cfg_wdata;
                CFG_HEIGHT: cfg_reg.map_height  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bmdi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .status   (front_status)
    );

    bmdi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (back_status)
    );

`ifndef ASSERT_OFF
    // A queued transaction is visible to the back end on the next cycle.
    a_push_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser != ACT_NONE)) |=> (front_status.count != 2'd0))
        else $error("accepted transaction not queued");

    // A result only appears after the last finish step.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(back_status.state == ST_F3))
        else $error("result without finish");

    // The back end only dequeues when idle and the queue holds a transaction.
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_valid && (back_status.state == ST_IDLE)))
        else $error("dequeue while busy or empty");
`endif

endmodule
